FILE: rtl/dqo_pkg.sv
// Shared types, constants and helper functions for the dual quadrature odometry block.
package dqo_pkg;

   // Operand and product widths of the shared multiplier.
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   // Angle constants in Q16.16.
   localparam logic [31:0]        Q_TWO_PI_U = 32'd411775;
   localparam logic signed [19:0] Q_TWO_PI   = 20'sd411775;
   localparam logic signed [19:0] Q_PI       = 20'sd205887;
   localparam logic signed [19:0] Q_HALF_PI  = 20'sd102944;

   // CORDIC start magnitude in Q2.30 (inverse of the rotation gain).
   localparam logic signed [MUL_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // Reciprocal of 2pi scaled by 2^MOD_SHIFT and rounded down. For an angle
   // magnitude up to 2^31 the quotient taken from it is exact or one short,
   // so one compare and subtract finishes the remainder.
   localparam int MOD_SHIFT = 50;
   localparam logic signed [MUL_W-1:0] MOD_RECIP =
      MUL_W'((64'd1 << MOD_SHIFT) / {32'd0, Q_TWO_PI_U});

   // Configuration register indexes.
   localparam logic REG_DISTANCE_PER_COUNT = 1'b0;
   localparam logic REG_INVERSE_WHEEL_BASE = 1'b1;

   typedef enum logic [1:0] {
      CH_RIGHT_A = 2'd0,
      CH_RIGHT_B = 2'd1,
      CH_LEFT_A  = 2'd2,
      CH_LEFT_B  = 2'd3
   } channel_type;

   typedef struct packed {
      channel_type channel;
      logic        level_a;
      logic        level_b;
   } pin_event_type;

   typedef struct packed {
      logic signed [31:0] turn_angle;
      logic signed [31:0] y_distance;
      logic signed [31:0] x_distance;
   } result_type;

   // Arctangent of 2^-i in Q16.16.
   function automatic logic [15:0] atan_entry(input logic [4:0] idx);
      logic [15:0] val;
      case (idx)
         5'd0:    val = 16'd51472;
         5'd1:    val = 16'd30385;
         5'd2:    val = 16'd16055;
         5'd3:    val = 16'd8150;
         5'd4:    val = 16'd4091;
         5'd5:    val = 16'd2047;
         5'd6:    val = 16'd1024;
         5'd7:    val = 16'd512;
         5'd8:    val = 16'd256;
         5'd9:    val = 16'd128;
         5'd10:   val = 16'd64;
         5'd11:   val = 16'd32;
         5'd12:   val = 16'd16;
         5'd13:   val = 16'd8;
         5'd14:   val = 16'd4;
         5'd15:   val = 16'd2;
         5'd16:   val = 16'd1;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

   // Saturate a full-width product to a signed 32-bit value.
   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] res;
      if (v[PROD_W-1:31] == '0 || v[PROD_W-1:31] == '1) begin
         res = v[31:0];
      end else if (v[PROD_W-1]) begin
         res = 32'sh8000_0000;
      end else begin
         res = 32'sh7fff_ffff;
      end
      return res;
   endfunction

endpackage

FILE: rtl/dqo_counts.sv
// Saturating x4 quadrature counters for the right and left wheels.
module dqo_counts #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          edge_en,
   input  dqo_pkg::pin_event_type        pin_event,
   input  logic                          clear,
   output logic signed [COUNT_WIDTH-1:0] right_count,
   output logic signed [COUNT_WIDTH-1:0] left_count
);
   import dqo_pkg::*;

   localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   logic signed [COUNT_WIDTH-1:0] right_ff, right_in;
   logic signed [COUNT_WIDTH-1:0] left_ff, left_in;
   logic                          levels_differ;
   logic                          is_right;
   logic                          up;
   logic signed [COUNT_WIDTH-1:0] cur;
   logic signed [COUNT_WIDTH-1:0] bumped;

   assign levels_differ = pin_event.level_a ^ pin_event.level_b;

   always_comb begin
      unique case (pin_event.channel)
         CH_RIGHT_A: begin
            is_right = 1'b1;
            up       = levels_differ;
         end
         CH_RIGHT_B: begin
            is_right = 1'b1;
            up       = ~levels_differ;
         end
         CH_LEFT_A: begin
            is_right = 1'b0;
            up       = ~levels_differ;
         end
         default: begin
            is_right = 1'b0;
            up       = levels_differ;
         end
      endcase
   end

   assign cur = is_right ? right_ff : left_ff;

   always_comb begin
      if (up) begin
         bumped = (cur == CNT_MAX) ? CNT_MAX : cur + 1'b1;
      end else begin
         bumped = (cur == CNT_MIN) ? CNT_MIN : cur - 1'b1;
      end
   end

   always_comb begin
      right_in = right_ff;
      left_in  = left_ff;
      if (clear) begin
         right_in = '0;
         left_in  = '0;
      end else if (edge_en) begin
         if (is_right) begin
            right_in = bumped;
         end else begin
            left_in = bumped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff <= '0;
         left_ff  <= '0;
      end else begin
         right_ff <= right_in;
         left_ff  <= left_in;
      end
   end

   assign right_count = right_ff;
   assign left_count  = left_ff;

endmodule

FILE: rtl/dqo_mul.sv
// Shared signed multiplier with a registered product.
module dqo_mul (
   input  logic                               clock,
   input  logic signed [dqo_pkg::MUL_W-1:0]   op_a,
   input  logic signed [dqo_pkg::MUL_W-1:0]   op_b,
   output logic signed [dqo_pkg::PROD_W-1:0]  product
);
   import dqo_pkg::*;

   logic signed [PROD_W-1:0] product_ff, product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

FILE: rtl/dqo_engine.sv
// Update sequencer: distances, turn angle, angle reduction and CORDIC rotation.
module dqo_engine #(
   parameter int COUNT_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [COUNT_WIDTH-1:0] right_count,
   input  logic signed [COUNT_WIDTH-1:0] left_count,
   input  logic [31:0]                   distance_per_count,
   input  logic [31:0]                   inverse_wheel_base,
   output logic                          idle,
   output logic                          res_valid,
   input  logic                          res_ready,
   output dqo_pkg::result_type           result
);
   import dqo_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

   typedef enum logic [15:0] {
      S_IDLE  = 16'b0000000000000001,
      S_MUL_R = 16'b0000000000000010,
      S_MUL_L = 16'b0000000000000100,
      S_DIFF  = 16'b0000000000001000,
      S_MUL_A = 16'b0000000000010000,
      S_ANGLE = 16'b0000000000100000,
      S_MUL_Q = 16'b0000000001000000,
      S_MUL_M = 16'b0000000010000000,
      S_REM   = 16'b0000000100000000,
      S_MOD   = 16'b0000001000000000,
      S_FOLD  = 16'b0000010000000000,
      S_ROT   = 16'b0000100000000000,
      S_MUL_X = 16'b0001000000000000,
      S_MUL_Y = 16'b0010000000000000,
      S_YSAT  = 16'b0100000000000000,
      S_DONE  = 16'b1000000000000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [COUNT_WIDTH-1:0] rc_ff, lc_ff;
   logic signed [31:0]            dr_ff, mean_ff, theta_ff, xo_ff, yo_ff;
   logic                          neg_ff, flip_ff;
   logic [31:0]                   mag_ff, rem_ff;
   logic signed [19:0]            z_ff;
   logic signed [MUL_W-1:0]       x_ff, y_ff;
   logic [STEP_W-1:0]             step_ff;

   logic signed [MUL_W-1:0]       mul_a, mul_b;
   logic signed [PROD_W-1:0]      prod;

   // Datapath helper values.
   logic signed [31:0] dl;
   logic signed [32:0] diff, sum;
   logic [63:0]        p_round;
   logic [47:0]        q;
   logic signed [31:0] theta;
   logic [31:0]        theta_mag;
   logic [63-MOD_SHIFT:0] quot;
   logic signed [19:0] r1, r2;
   logic signed [MUL_W-1:0] xs, ys;
   logic signed [19:0] at;

   dqo_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MUL_R: begin
            mul_a = {{(MUL_W-COUNT_WIDTH){rc_ff[COUNT_WIDTH-1]}}, rc_ff};
            mul_b = {2'b00, distance_per_count};
         end
         S_MUL_L: begin
            mul_a = {{(MUL_W-COUNT_WIDTH){lc_ff[COUNT_WIDTH-1]}}, lc_ff};
            mul_b = {2'b00, distance_per_count};
         end
         S_MUL_A: begin
            mul_a = {2'b00, mag_ff};
            mul_b = {2'b00, inverse_wheel_base};
         end
         S_MUL_Q: begin
            mul_a = {2'b00, rem_ff};
            mul_b = MOD_RECIP;
         end
         S_MUL_M: begin
            mul_a = MUL_W'(quot);
            mul_b = {2'b00, Q_TWO_PI_U};
         end
         S_MUL_X: begin
            mul_a = {{2{mean_ff[31]}}, mean_ff};
            mul_b = flip_ff ? -y_ff : y_ff;
         end
         S_MUL_Y: begin
            mul_a = {{2{mean_ff[31]}}, mean_ff};
            mul_b = flip_ff ? -x_ff : x_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Wheel distances, their difference and mean.
   assign dl   = sat32(prod);
   assign diff = {dl[31], dl} - {dr_ff[31], dr_ff};
   assign sum  = {dl[31], dl} + {dr_ff[31], dr_ff};

   // Turn angle: the magnitude product rounded away from zero for a negative
   // difference, which equals a floor shift of the signed product.
   assign p_round = neg_ff ? prod[63:0] + 64'h0000_0000_0000_ffff : prod[63:0];
   assign q       = p_round[63:16];

   always_comb begin
      if (neg_ff) begin
         theta = (q > 48'h0000_8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
      end else begin
         theta = (q > 48'h0000_7fff_ffff) ? 32'sh7fff_ffff : $signed(q[31:0]);
      end
   end

   assign theta_mag = theta[31] ? 32'(-theta) : 32'(theta);

   // Quotient estimate of the angle magnitude by 2pi from the reciprocal product.
   assign quot = prod[63:MOD_SHIFT];

   // Floor remainder modulo 2pi, then fold into [-pi/2, pi/2].
   always_comb begin
      if (theta_ff[31] && rem_ff != '0) begin
         r1 = Q_TWO_PI - $signed({1'b0, rem_ff[18:0]});
      end else begin
         r1 = $signed({1'b0, rem_ff[18:0]});
      end
      r2 = (r1 > Q_PI) ? r1 - Q_TWO_PI : r1;
   end

   // One CORDIC micro-rotation per cycle.
   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign at = $signed({4'b0000, atan_entry(5'(step_ff))});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (start) state_in = S_MUL_R;
         S_MUL_R: state_in = S_MUL_L;
         S_MUL_L: state_in = S_DIFF;
         S_DIFF:  state_in = S_MUL_A;
         S_MUL_A: state_in = S_ANGLE;
         S_ANGLE: state_in = S_MUL_Q;
         S_MUL_Q: state_in = S_MUL_M;
         S_MUL_M: state_in = S_REM;
         S_REM:   state_in = S_MOD;
         S_MOD:   state_in = S_FOLD;
         S_FOLD:  state_in = S_ROT;
         S_ROT:   if (step_ff == STEP_LAST) state_in = S_MUL_X;
         S_MUL_X: state_in = S_MUL_Y;
         S_MUL_Y: state_in = S_YSAT;
         S_YSAT:  state_in = S_DONE;
         S_DONE:  if (res_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            rc_ff <= right_count;
            lc_ff <= left_count;
         end
         S_MUL_L: begin
            dr_ff <= sat32(prod);
         end
         S_DIFF: begin
            neg_ff  <= diff[32];
            mag_ff  <= diff[32] ? 32'(-diff) : 32'(diff);
            mean_ff <= sum[32:1];
         end
         S_ANGLE: begin
            theta_ff <= theta;
            rem_ff   <= theta_mag;
         end
         S_REM: begin
            rem_ff <= rem_ff - prod[31:0];
         end
         S_MOD: begin
            // The quotient estimate may be one short; take off one more 2pi.
            if (rem_ff >= Q_TWO_PI_U) begin
               rem_ff <= rem_ff - Q_TWO_PI_U;
            end
         end
         S_FOLD: begin
            if (r2 > Q_HALF_PI) begin
               z_ff    <= r2 - Q_PI;
               flip_ff <= 1'b1;
            end else if (r2 < -Q_HALF_PI) begin
               z_ff    <= r2 + Q_PI;
               flip_ff <= 1'b1;
            end else begin
               z_ff    <= r2;
               flip_ff <= 1'b0;
            end
            x_ff    <= CORDIC_GAIN;
            y_ff    <= '0;
            step_ff <= '0;
         end
         S_ROT: begin
            if (!z_ff[19]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end
            step_ff <= step_ff + 1'b1;
         end
         S_MUL_Y: begin
            xo_ff <= sat32(prod >>> 30);
         end
         S_YSAT: begin
            yo_ff <= sat32(prod >>> 30);
         end
         default: begin
         end
      endcase
   end

   assign idle              = (state_ff == S_IDLE);
   assign res_valid         = (state_ff == S_DONE);
   assign result.x_distance = xo_ff;
   assign result.y_distance = yo_ff;
   assign result.turn_angle = theta_ff;

endmodule

FILE: rtl/dual_quadrature_odometry.sv
// Top level of the dual-wheel quadrature odometry block.
//
// The req_ stream carries two kinds of items, told apart by req_tuser. With
// req_tuser low the item is an encoder pin edge: req_tdata names the pin that
// changed and gives that wheel's A and B levels after the change. Such a
// transfer moves the matching saturating x4 count up or down and produces no
// result. With req_tuser high the item is an update request: both counts are
// captured and cleared, turned into Q16.16 distances and a turn angle, and the
// mean distance is split into x and y with a CORDIC rotation.
// One result transfer leaves on the rsp_ stream per update.
// An update runs on one shared multiplier and one shift/add datapath under a
// sequencer: it reduces the angle modulo 2pi by a reciprocal multiply and a
// correcting subtract, then runs the CORDIC micro-rotations. req_tready
// stays low until rsp_tvalid rises, so no new request is taken while an
// update runs. Edge items are taken every cycle while the sequencer is idle.
// The result sits in an output register, so a stalled receiver does not hold
// up edge items; a second update waits in its last step until that register
// is free. Reset clears both counts, sets both csr registers to 1.0 and
// empties the output register.
module dual_quadrature_odometry #(
   parameter int COUNT_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [1:0] edge_channel, [2] level_a, [3] level_b, zero pad
   input  logic        req_tuser,   // [0] action
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] x_distance, [63:32] y_distance, [95:64] turn_angle
   // Register write port.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import dqo_pkg::*;

   logic [31:0]                   dist_per_count_ff, dist_per_count_in;
   logic [31:0]                   inv_wheel_base_ff, inv_wheel_base_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [95:0]                   rsp_data_ff, rsp_data_in;

   logic                          req_xfer;
   logic                          edge_en;
   logic                          start;
   pin_event_type                 pin_event;
   logic signed [COUNT_WIDTH-1:0] right_count, left_count;
   logic                          engine_idle;
   logic                          res_valid;
   logic                          res_ready;
   result_type                    result;

   assign req_tready = engine_idle;
   assign req_xfer   = req_tvalid & req_tready;
   assign edge_en    = req_xfer & ~req_tuser;
   assign start      = req_xfer & req_tuser;

   assign pin_event.channel = channel_type'(req_tdata[1:0]);
   assign pin_event.level_a = req_tdata[2];
   assign pin_event.level_b = req_tdata[3];

   dqo_counts #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_counts (
      .clock       (clock),
      .reset       (reset),
      .edge_en     (edge_en),
      .pin_event   (pin_event),
      .clear       (start),
      .right_count (right_count),
      .left_count  (left_count)
   );

   dqo_engine #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_engine (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .right_count        (right_count),
      .left_count         (left_count),
      .distance_per_count (dist_per_count_ff),
      .inverse_wheel_base (inv_wheel_base_ff),
      .idle               (engine_idle),
      .res_valid          (res_valid),
      .res_ready          (res_ready),
      .result             (result)
   );

   // The user must write the configuration registers only while no update is running; the block does not enforce it.
   always_comb begin
      dist_per_count_in = dist_per_count_ff;
      inv_wheel_base_in = inv_wheel_base_ff;
      if (csr_we) begin
         if (csr_index == REG_DISTANCE_PER_COUNT) begin
            dist_per_count_in = csr_wdata;
         end
         if (csr_index == REG_INVERSE_WHEEL_BASE) begin
            inv_wheel_base_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_per_count_ff <= 32'h0001_0000;
         inv_wheel_base_ff <= 32'h0001_0000;
      end else begin
         dist_per_count_ff <= dist_per_count_in;
         inv_wheel_base_ff <= inv_wheel_base_in;
      end
   end

   // Output register: takes a new result once the previous one has gone.
   assign res_ready = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = {result.turn_angle, result.y_distance, result.x_distance};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
